/* rtl/core/odth_pkg.sv */
// Shared types, constants and field widths for the origin-destination transition histogram.
package odth_pkg;

	localparam int TOWERS      = 2048;
	localparam int COUNT_BITS  = 32;
	localparam int USER_W      = 22;
	localparam int TIME_W      = 31;
	localparam int TOWER_W     = 11;
	localparam int CELL_W      = 32;
	localparam int TW          = $clog2(TOWERS);
	localparam int ADDR_W      = 2 * TW;
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_AW        = $clog2(QUEUE_DEPTH);
	localparam int IN_DATA_W   = 88;
	localparam int OUT_DATA_W  = 80;

	localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(72000000);

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [ADDR_W-1:0]     addr_t;

	localparam count_t COUNT_MAX = '1;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_TRIP = 2'd1,
		KIND_READ = 2'd2,
		KIND_MISS = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [TOWER_W-1:0] origin;
		logic [TOWER_W-1:0] dest;
		logic [USER_W-1:0]  users;
	} op_t;

endpackage

/* rtl/core/odth_front.sv */
// Front end: accepts words, tracks the previous record and classifies each word.
module odth_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [odth_pkg::TIME_W-1:0]    cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [odth_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [0:0]                     s_tuser,
	input  logic                           q_full,
	input  logic                           clearing,
	output logic                           push,
	output odth_pkg::op_t                  push_op
);
	import odth_pkg::*;

	logic [TIME_W-1:0]  window_q;
	logic [USER_W-1:0]  prev_user_q;
	logic [TIME_W-1:0]  prev_time_q;
	logic [TOWER_W-1:0] prev_tower_q;
	logic               prev_valid_q;
	logic               counted_q;
	logic [USER_W-1:0]  users_q;

	logic               opcode;
	logic [USER_W-1:0]  user;
	logic [TIME_W-1:0]  call_time;
	logic [TOWER_W-1:0] tower;
	logic [TOWER_W-1:0] read_origin;
	logic [TOWER_W-1:0] read_dest;
	logic               accept;
	logic               same;
	logic [TIME_W:0]    gap;
	logic               in_window;
	logic               towers_ok;
	logic               read_ok;
	logic               trip;
	logic               new_user;
	logic [USER_W-1:0]  users_next;

	assign opcode      = s_tuser[0];
	assign user        = s_tdata[21:0];
	assign call_time   = s_tdata[52:22];
	assign tower       = s_tdata[63:53];
	assign read_origin = s_tdata[74:64];
	assign read_dest   = s_tdata[85:75];

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full && !clearing;
	assign accept    = s_tvalid && s_tready;

	assign same      = prev_valid_q && (user == prev_user_q);
	assign gap       = {1'b0, call_time} - {1'b0, prev_time_q};
	assign in_window = !gap[TIME_W] && (gap[TIME_W-1:0] <= window_q);
	assign towers_ok = (32'(prev_tower_q) < 32'(TOWERS)) && (32'(tower) < 32'(TOWERS));
	assign read_ok   = (32'(read_origin) < 32'(TOWERS)) && (32'(read_dest) < 32'(TOWERS));
	assign trip      = same && in_window && (tower != prev_tower_q) && towers_ok;
	assign new_user  = trip && !(same && counted_q);
	assign users_next = (new_user && (users_q != '1)) ? users_q + USER_W'(1) : users_q;

	always_comb begin
		push_op = '0;
		if (opcode) begin
			push_op.kind   = read_ok ? KIND_READ : KIND_MISS;
			push_op.origin = read_origin;
			push_op.dest   = read_dest;
			push_op.users  = users_q;
		end else begin
			push_op.kind   = trip ? KIND_TRIP : KIND_NONE;
			push_op.origin = prev_tower_q;
			push_op.dest   = tower;
			push_op.users  = users_next;
		end
	end

	assign push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WINDOW_RESET;
			prev_user_q  <= '0;
			prev_time_q  <= '0;
			prev_tower_q <= '0;
			prev_valid_q <= 1'b0;
			counted_q    <= 1'b0;
			users_q      <= '0;
		end else begin
			if (cfg_valid) begin
				window_q <= cfg_data;
			end
			if (accept && !opcode) begin
				prev_user_q  <= user;
				prev_time_q  <= call_time;
				prev_tower_q <= tower;
				prev_valid_q <= 1'b1;
				counted_q    <= same ? (counted_q || trip) : trip;
				users_q      <= users_next;
			end
		end
	end

endmodule

/* rtl/core/odth_queue.sv */
// Small register queue that decouples the front end from the matrix update.
module odth_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  odth_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output odth_pkg::op_t head
);
	import odth_pkg::*;

	op_t             slot_q [QUEUE_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   fill_q;

	assign full  = (fill_q == (Q_AW + 1)'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (Q_AW + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (Q_AW + 1)'(1);
			end
		end
	end

endmodule

/* rtl/core/odth_back.sv */
// Back end: clears the matrix after reset, then runs the cell read-modify-write and output register.
module odth_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            empty,
	input  odth_pkg::op_t                   head,
	output logic                            pop,
	output logic                            clearing,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [odth_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [0:0]                      m_tuser
);
	import odth_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} back_state_t;

	back_state_t state_q;
	addr_t       clr_addr_q;

	count_t      mem [1 << ADDR_W];

	logic        valid_s2;
	op_t         op_s2;
	addr_t       addr_s2;
	count_t      rdata_s2;
	logic        fwd_hit_s2;
	count_t      fwd_data_s2;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_trip_q;

	addr_t       rd_addr;
	count_t      old_s2;
	count_t      new_s2;
	logic        advance;
	logic        trip_wr;
	logic        mem_we;
	addr_t       mem_wa;
	count_t      mem_wd;
	logic [TOWER_W-1:0] res_origin;
	logic [TOWER_W-1:0] res_dest;
	logic [CELL_W-1:0]  res_cell;

	assign clearing = (state_q == ST_CLEAR);
	assign advance  = valid_s2 && (!out_valid_q || m_tready);
	assign pop      = !empty && (state_q == ST_RUN) && (!valid_s2 || advance);
	assign rd_addr  = {TW'(head.origin), TW'(head.dest)};

	assign old_s2  = fwd_hit_s2 ? fwd_data_s2 : rdata_s2;
	assign new_s2  = (old_s2 == COUNT_MAX) ? old_s2 : old_s2 + COUNT_BITS'(1);
	assign trip_wr = advance && (op_s2.kind == KIND_TRIP);

	assign mem_we = clearing || trip_wr;
	assign mem_wa = clearing ? clr_addr_q : addr_s2;
	assign mem_wd = clearing ? '0 : new_s2;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (pop) begin
			rdata_s2 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s2       <= head;
			addr_s2     <= rd_addr;
			fwd_hit_s2  <= trip_wr && (addr_s2 == rd_addr);
			fwd_data_s2 <= new_s2;
		end
	end

	always_comb begin
		res_origin = '0;
		res_dest   = '0;
		res_cell   = '0;
		case (op_s2.kind)
			KIND_TRIP: begin
				res_origin = op_s2.origin;
				res_dest   = op_s2.dest;
				res_cell   = CELL_W'(new_s2);
			end
			KIND_READ: begin
				res_origin = op_s2.origin;
				res_dest   = op_s2.dest;
				res_cell   = CELL_W'(old_s2);
			end
			KIND_MISS: begin
				res_origin = op_s2.origin;
				res_dest   = op_s2.dest;
			end
			default: begin
				res_cell = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'b0000, op_s2.users, res_cell, res_dest, res_origin};
			out_trip_q <= (op_s2.kind == KIND_TRIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == '1) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (pop) begin
				valid_s2 <= 1'b1;
			end else if (advance) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_trip_q;

endmodule

/* rtl/core/od_transition_histogram.sv */
// Top level of the origin-destination transition histogram.
// Path: an accepted word goes through the queue, stage 2 and the output register.
// Throughput: one word per cycle unless the output stalls, set by one read and one
// write of the count memory per cycle, with forwarding when back-to-back trips update
// the same cell. Reset: asynchronous; then the count memory's 4194304 cells are cleared
// one per cycle while s_tready stays low; configuration writes are taken throughout.
module od_transition_histogram (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [odth_pkg::TIME_W-1:0]     cfg_data,    // trip_window
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// user_id[21:0], call_time[52:22], tower_id[63:53], read_origin[74:64], read_dest[85:75]
	input  logic [odth_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [0:0]                      s_tuser,     // opcode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// trip_origin[10:0], trip_dest[21:11], cell_count[53:22], users_with_trips[75:54]
	output logic [odth_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [0:0]                      m_tuser      // trip_counted
);
	import odth_pkg::*;

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	logic clearing;
	op_t  push_op;
	op_t  head;

	odth_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.clearing  (clearing),
		.push      (push),
		.push_op   (push_op)
	);

	odth_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.head    (head)
	);

	odth_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (head),
		.pop      (pop),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

/* rtl/core/odth_checker.sv */
// Port-level checks for the transition histogram and their attachment to the top level.
module odth_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [odth_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [0:0]                      m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Output word changed while stalled.");

	a_trip_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[10:0] != m_tdata[21:11]) && (m_tdata[53:22] != 0))
		else $error("Counted trip with equal towers or a zero cell.");

	a_trip_user: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[75:54] != 0)
		else $error("Counted trip while no user has trips.");

	a_users_grow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid || (m_tdata[75:54] >= $past(m_tdata[75:54])))
		else $error("User total decreased between words.");

endmodule

bind od_transition_histogram odth_checker u_odth_checker (.*);
